>>> src/chacha20_stream_cipher_assert.svh
// Assertion macros used by the cipher top level.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequence holds in the same cycle as the condition.
`define CC20_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cipher assertion failed");

// The consequence holds in the cycle after the condition.
`define CC20_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cipher assertion failed");

`else

`define CC20_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define CC20_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> src/cc20_pkg.sv
package cc20_pkg;

	// The four constant words of the initial block state.
	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;

	// Rotation amounts of the four quarter-round steps.
	localparam int ROT_0 = 16;
	localparam int ROT_1 = 12;
	localparam int ROT_2 = 8;
	localparam int ROT_3 = 7;

	localparam int BLOCK_BYTES = 64;
	localparam int POS_W = $clog2(BLOCK_BYTES);
	localparam int WORDS = 16;
	localparam int DOUBLE_ROUNDS_DEF = 10;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd6;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COL,
		ST_DIAG,
		ST_DROUND,
		ST_UNDIAG,
		ST_FEED,
		ST_EMIT
	} cc20_state_t;

	// Operations applied to the working word array.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_QR,
		OP_DIAG,
		OP_UNDIAG,
		OP_FEED,
		OP_SHIFT
	} cc20_op_t;

	// Commands from the sequencer to the word array.
	typedef struct packed {
		cc20_op_t op;
		logic [1:0] step;
		logic [3:0] idx;
	} cc20_ctl_t;

	// Status from the sequencer to the top level.
	typedef struct packed {
		logic load;
		logic emit;
		logic direct;
	} cc20_sts_t;

	// Key, nonce and block counter that form the initial state.
	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0] nonce_low;
		logic [31:0] nonce_high;
		logic [31:0] counter;
	} cc20_cfg_t;

endpackage

>>> src/cc20_alu.sv
module cc20_alu (
	input logic [31:0] p,
	input logic [31:0] q,
	input logic [31:0] r,
	input logic [1:0] step,
	output logic [31:0] sum,
	output logic [31:0] mix
);
	import cc20_pkg::*;

	logic [31:0] x;

	// Add, then fold the sum into the third word and rotate it.
	assign sum = p + q;
	assign x = r ^ sum;

	always_comb begin
		unique case (step)
			2'd0: mix = (x << ROT_0) | (x >> (32 - ROT_0));
			2'd1: mix = (x << ROT_1) | (x >> (32 - ROT_1));
			2'd2: mix = (x << ROT_2) | (x >> (32 - ROT_2));
			default: mix = (x << ROT_3) | (x >> (32 - ROT_3));
		endcase
	end

endmodule

>>> src/cc20_state.sv
module cc20_state (
	input logic clk,
	input cc20_pkg::cc20_ctl_t ctl,
	input cc20_pkg::cc20_cfg_t cfg,
	output logic [7:0] ks_byte
);
	import cc20_pkg::*;

	logic [31:0] w_q [WORDS];
	logic [31:0] w_d [WORDS];
	logic [31:0] tmp [WORDS];
	logic [31:0] init_w [WORDS];
	logic [31:0] alu_p;
	logic [31:0] alu_q;
	logic [31:0] alu_r;
	logic [31:0] alu_sum;
	logic [31:0] alu_mix;

	// Initial block state built from constants and configuration.
	always_comb begin
		init_w[0] = SIGMA_0;
		init_w[1] = SIGMA_1;
		init_w[2] = SIGMA_2;
		init_w[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = cfg.key[i][31:0];
			init_w[5 + 2 * i] = cfg.key[i][63:32];
		end
		init_w[12] = cfg.counter;
		init_w[13] = cfg.nonce_low[31:0];
		init_w[14] = cfg.nonce_low[63:32];
		init_w[15] = cfg.nonce_high;
	end

	// Operand selection: quarter rounds always work on column zero.
	always_comb begin
		if (ctl.op == OP_FEED) begin
			alu_p = w_q[0];
			alu_q = init_w[ctl.idx];
			alu_r = w_q[12];
		end else if (!ctl.step[0]) begin
			alu_p = w_q[0];
			alu_q = w_q[4];
			alu_r = w_q[12];
		end else begin
			alu_p = w_q[8];
			alu_q = w_q[12];
			alu_r = w_q[4];
		end
	end

	cc20_alu u_alu (
		.p(alu_p),
		.q(alu_q),
		.r(alu_r),
		.step(ctl.step),
		.sum(alu_sum),
		.mix(alu_mix)
	);

	// Next value of the word array for each operation.
	always_comb begin
		tmp = w_q;
		w_d = w_q;
		unique case (ctl.op)
			OP_LOAD: begin
				w_d = init_w;
			end
			OP_QR: begin
				if (!ctl.step[0]) begin
					tmp[0] = alu_sum;
					tmp[12] = alu_mix;
				end else begin
					tmp[8] = alu_sum;
					tmp[4] = alu_mix;
				end
				// After the last step of a quarter round, the next column moves to column zero.
				if (ctl.step == 2'd3) begin
					for (int r = 0; r < 4; r++) begin
						for (int j = 0; j < 4; j++) begin
							w_d[4 * r + j] = tmp[4 * r + ((j + 1) % 4)];
						end
					end
				end else begin
					w_d = tmp;
				end
			end
			OP_DIAG: begin
				// Row r turns left by r, so the diagonals become columns.
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						w_d[4 * r + j] = w_q[4 * r + ((j + r) % 4)];
					end
				end
			end
			OP_UNDIAG: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						w_d[4 * r + ((j + r) % 4)] = w_q[4 * r + j];
					end
				end
			end
			OP_FEED: begin
				// Words pass through position zero, each picking up its initial value.
				for (int i = 0; i < WORDS - 1; i++) begin
					w_d[i] = w_q[i + 1];
				end
				w_d[WORDS - 1] = alu_sum;
			end
			OP_SHIFT: begin
				// The whole block moves down by one byte.
				for (int i = 0; i < WORDS - 1; i++) begin
					w_d[i] = {w_q[i + 1][7:0], w_q[i][31:8]};
				end
				w_d[WORDS - 1] = {8'h00, w_q[WORDS - 1][31:8]};
			end
			default: begin
				w_d = w_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
	end

	assign ks_byte = w_q[0][7:0];

endmodule

>>> src/cc20_ctrl.sv
module cc20_ctrl #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	input logic new_message,
	input logic block_ready,
	input logic out_free,
	output logic data_ready,
	output cc20_pkg::cc20_ctl_t ctl,
	output cc20_pkg::cc20_sts_t sts
);
	import cc20_pkg::*;

	localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

	cc20_state_t state_q;
	cc20_state_t state_d;
	logic [3:0] cnt_q;
	logic [DR_W-1:0] dr_q;
	logic accept;
	logic need;
	logic last_dr;

	assign accept = data_valid && data_ready;
	assign need = new_message || !block_ready;
	assign last_dr = (dr_q == DR_W'(DOUBLE_ROUNDS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && need) state_d = ST_COL;
			ST_COL: if (cnt_q == 4'd15) state_d = ST_DIAG;
			ST_DIAG: state_d = ST_DROUND;
			ST_DROUND: if (cnt_q == 4'd15) state_d = ST_UNDIAG;
			ST_UNDIAG: state_d = last_dr ? ST_FEED : ST_COL;
			ST_FEED: if (cnt_q == 4'd15) state_d = ST_EMIT;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		data_ready = 1'b0;
		ctl.op = OP_HOLD;
		ctl.step = cnt_q[1:0];
		ctl.idx = cnt_q;
		sts = '0;
		unique case (state_q)
			ST_IDLE: begin
				data_ready = out_free;
				if (accept) begin
					ctl.op = need ? OP_LOAD : OP_SHIFT;
					sts.load = need;
					sts.emit = !need;
					sts.direct = !need;
				end
			end
			ST_COL, ST_DROUND: ctl.op = OP_QR;
			ST_DIAG: ctl.op = OP_DIAG;
			ST_UNDIAG: ctl.op = OP_UNDIAG;
			ST_FEED: ctl.op = OP_FEED;
			ST_EMIT: begin
				ctl.op = OP_SHIFT;
				sts.emit = 1'b1;
			end
			default: ctl.op = OP_HOLD;
		endcase
	end

	// State register, step counter and double-round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			dr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_COL || state_q == ST_DROUND || state_q == ST_FEED) begin
				cnt_q <= cnt_q + 4'd1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_IDLE) begin
				dr_q <= '0;
			end else if (state_q == ST_UNDIAG) begin
				dr_q <= dr_q + DR_W'(1);
			end
		end
	end

endmodule

>>> src/chacha20_stream_cipher.sv
// Channel   Handshake                  Payload
// input     data_valid / data_ready    data_byte, new_message
// output    result_valid / result_ready cipher_byte
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A live-block byte is registered in the next cycle; one byte a cycle while result_ready is high.
// A byte that opens a block waits while the block is generated on the single add-xor-rotate unit,
// one quarter-round step a cycle, before its result is registered in the emit state.
// The input is not ready while a block is generated or while a result waits with result_ready low.
// Reset clears the control state and the configuration; the keystream words are not reset.
`include "chacha20_stream_cipher_assert.svh"

module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	output logic data_ready,
	input logic [7:0] data_byte,
	input logic new_message,
	output logic result_valid,
	input logic result_ready,
	output logic [7:0] cipher_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [63:0] cfg_data
);
	import cc20_pkg::*;

	cc20_cfg_t cfg_q;
	cc20_ctl_t ctl;
	cc20_sts_t sts;
	logic [7:0] ks_byte;
	logic [7:0] data_q;
	logic [7:0] cipher_q;
	logic result_valid_q;
	logic [POS_W-1:0] pos_q;
	logic block_ready_q;
	logic out_free;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;
	assign out_free = !result_valid_q || result_ready;

	cc20_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.new_message(new_message),
		.block_ready(block_ready_q),
		.out_free(out_free),
		.data_ready(data_ready),
		.ctl(ctl),
		.sts(sts)
	);

	cc20_state u_state (
		.clk(clk),
		.ctl(ctl),
		.cfg(cfg_q),
		.ks_byte(ks_byte)
	);

	// Configuration registers; the counter also advances after each generated block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_0: cfg_q.key[0] <= cfg_data;
					REG_KEY_1: cfg_q.key[1] <= cfg_data;
					REG_KEY_2: cfg_q.key[2] <= cfg_data;
					REG_KEY_3: cfg_q.key[3] <= cfg_data;
					REG_NONCE_LOW: cfg_q.nonce_low <= cfg_data;
					REG_NONCE_HIGH: cfg_q.nonce_high <= cfg_data[31:0];
					REG_INIT_CTR: cfg_q.counter <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (sts.emit && !sts.direct && !(cfg_we && cfg_index == REG_INIT_CTR)) begin
				cfg_q.counter <= cfg_q.counter + 32'd1;
			end
		end
	end

	// Position inside the current block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			block_ready_q <= 1'b0;
		end else if (sts.load) begin
			pos_q <= '0;
			block_ready_q <= 1'b1;
		end else if (sts.emit) begin
			pos_q <= pos_q + POS_W'(1);
			if (pos_q == POS_W'(BLOCK_BYTES - 1)) begin
				block_ready_q <= 1'b0;
			end
		end
	end

	// The byte waits here while its block is generated.
	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			data_q <= data_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (sts.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.emit) begin
			cipher_q <= (sts.direct ? data_byte : data_q) ^ ks_byte;
		end
	end

	assign result_valid = result_valid_q;
	assign cipher_byte = cipher_q;

	`CC20_ASSERT_SAME(a_emit_slot_free, clk, arst_n, sts.emit, out_free)
	`CC20_ASSERT_SAME(a_direct_needs_block, clk, arst_n, sts.direct, block_ready_q)
	`CC20_ASSERT_NEXT(a_counter_step, clk, arst_n,
		sts.emit && !sts.direct && !cfg_we, cfg_q.counter == $past(cfg_q.counter) + 32'd1)

endmodule
